[sv/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// shared types, constants and step functions of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int RADIUS_MAX_DEF = 63;
	localparam int MAX_RESULTS    = 46;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] MASK_AXIS   = 8'h53;
	localparam logic [7:0] MASK_SINGLE = 8'h01;
	localparam logic [7:0] MASK_DIAG   = 8'h0F;
	localparam logic [7:0] MASK_FULL   = 8'hFF;

	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	typedef logic [9:0]         center_t;
	typedef logic [5:0]         off_t;
	typedef logic signed [8:0]  dec_t;
	typedef logic signed [11:0] coord_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef struct packed {
		center_t row;
		center_t col;
		off_t    rad;
	} job_t;

	typedef struct packed {
		off_t x;
		off_t y;
		dec_t p;
	} pt_t;

	typedef struct packed {
		coord_t     row_plus_a;
		coord_t     row_minus_a;
		coord_t     row_plus_b;
		coord_t     row_minus_b;
		coord_t     col_plus_a;
		coord_t     col_minus_a;
		coord_t     col_plus_b;
		coord_t     col_minus_b;
		logic [7:0] point_mask;
	} res_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_RUN
	} eng_st_t;

	typedef struct packed {
		logic busy;
		cnt_t count;
	} eng_stat_t;

	typedef struct packed {
		logic [$clog2(QUEUE_DEPTH + 1)-1:0] count;
	} q_stat_t;

	// one midpoint step: y advances, x steps back when the decision is positive
	function automatic pt_t mid_step(pt_t c);
		pt_t                nx;
		logic signed [9:0]  t;
		nx.y = c.y + 6'd1;
		nx.x = c.x;
		t = {c.p[8], c.p} + $signed({3'b000, nx.y, 1'b0}) + 10'sd1;
		if (c.p > 9'sd0) begin
			nx.x = c.x - 6'd1;
			t = t - $signed({3'b000, nx.x, 1'b0});
		end
		nx.p = t[8:0];
		return nx;
	endfunction

	function automatic res_t make_res(center_t row, center_t col, off_t a, off_t b,
		logic [7:0] mask);
		res_t r;
		r.row_plus_a  = {2'b00, row} + {6'd0, a};
		r.row_minus_a = {2'b00, row} - {6'd0, a};
		r.row_plus_b  = {2'b00, row} + {6'd0, b};
		r.row_minus_b = {2'b00, row} - {6'd0, b};
		r.col_plus_a  = {2'b00, col} + {6'd0, a};
		r.col_minus_a = {2'b00, col} - {6'd0, a};
		r.col_plus_b  = {2'b00, col} + {6'd0, b};
		r.col_minus_b = {2'b00, col} - {6'd0, b};
		r.point_mask  = mask;
		return r;
	endfunction

endpackage

[sv/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front
// request intake: registers one circle request and saturates its radius
// ----------------------------------------------------------------------------
module mcr_front #(
	parameter int RADIUS_MAX = mcr_pkg::RADIUS_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mcr_pkg::job_t in_job,
	output logic          push_valid,
	input  logic          push_ready,
	output mcr_pkg::job_t push_job
);
	import mcr_pkg::*;

	localparam logic [7:0] RMAX = 8'(RADIUS_MAX);

	logic valid_s1;
	job_t job_s1;
	job_t job_c;

	always_comb begin
		job_c = in_job;
		if ({2'b00, in_job.rad} > RMAX) begin
			job_c.rad = RMAX[5:0];
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_c;
		end
	end

endmodule

[sv/mcr_queue.sv]
// ----------------------------------------------------------------------------
// mcr_queue
// short request queue between intake and the point engine
// ----------------------------------------------------------------------------
module mcr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  mcr_pkg::job_t   wr_job,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mcr_pkg::job_t   rd_job,
	output mcr_pkg::q_stat_t stat
);
	import mcr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

	job_t          mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready   = (count_q != CNT_FULL);
	assign rd_valid   = (count_q != '0);
	assign rd_job     = mem[rd_ptr_q];
	assign do_wr      = wr_valid && wr_ready;
	assign do_rd      = rd_valid && rd_ready;
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

endmodule

[sv/mcr_engine.sv]
// ----------------------------------------------------------------------------
// mcr_engine
// octant point sequencer with registered result output
// ----------------------------------------------------------------------------
module mcr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  mcr_pkg::job_t     job,
	output logic              res_valid,
	input  logic              res_ready,
	output mcr_pkg::res_t     res,
	output logic              res_last,
	output mcr_pkg::eng_stat_t stat
);
	import mcr_pkg::*;

	localparam cnt_t CNT_CAP = CNT_W'(MAX_RESULTS);

	eng_st_t st_q;
	eng_st_t st_d;
	pt_t     cur_q;
	cnt_t    n_q;
	center_t row_q;
	center_t col_q;
	logic    out_valid_q;
	res_t    out_q;
	logic    out_last_q;

	pt_t  pt1;
	pt_t  pt2;
	pt_t  pt0;
	cnt_t n1;
	logic out_free;
	logic load;
	logic step;
	logic last0;
	logic last1;

	assign out_free = !out_valid_q || res_ready;
	assign pt1      = mid_step(cur_q);
	assign pt2      = mid_step(pt1);
	assign n1       = n_q + 1'b1;
	assign last0    = (job.rad == '0);
	assign last1    = !(pt1.x > pt1.y) || (n1 >= CNT_CAP) || (pt2.x < pt2.y);

	always_comb begin
		pt0.x = job.rad;
		pt0.y = '0;
		pt0.p = 9'sd1 - $signed({3'b000, job.rad});
	end

	always_comb begin
		st_d = st_q;
		load = 1'b0;
		step = 1'b0;
		unique case (st_q)
			ENG_IDLE: begin
				if (job_valid && out_free) begin
					load = 1'b1;
					if (!last0) begin
						st_d = ENG_RUN;
					end
				end
			end
			ENG_RUN: begin
				if (out_free) begin
					step = 1'b1;
					if (last1) begin
						st_d = ENG_IDLE;
					end
				end
			end
			default: st_d = ENG_IDLE;
		endcase
	end

	assign job_ready  = load;
	assign res_valid  = out_valid_q;
	assign res        = out_q;
	assign res_last   = out_last_q;
	assign stat.busy  = (st_q == ENG_RUN);
	assign stat.count = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ENG_IDLE;
			out_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			st_q <= st_d;
			if (load || step) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				n_q <= cnt_t'(1);
			end else if (step) begin
				n_q <= n1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q      <= pt0;
			row_q      <= job.row;
			col_q      <= job.col;
			out_q      <= make_res(job.row, job.col, job.rad, '0,
				last0 ? MASK_SINGLE : MASK_AXIS);
			out_last_q <= last0;
		end else if (step) begin
			cur_q      <= pt1;
			out_q      <= make_res(row_q, col_q, pt1.x, pt1.y,
				(pt1.x == pt1.y) ? MASK_DIAG : MASK_FULL);
			out_last_q <= last1;
		end
	end

endmodule

[sv/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// circle request in, one result per octant point out, eight reflections each
// ----------------------------------------------------------------------------
// channel   dir  tdata bits                                   tlast
// s_axis    in   radius, center_col, center_row (26 of 32)    -
// m_axis    out  eight 12-bit coordinates, point_mask (104)   last_point
//
// a request passes the intake register and the queue, then the engine
// loads it and registers its first result; one result per cycle while the
// output is free, from a midpoint step and its lookahead copy, up to 46 per
// circle, and the first result of the next circle follows the last with no gap
// the queue takes requests until full while the engine waits on m_axis_tready
// reset clears the intake, queue and engine control only
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
	parameter int RADIUS_MAX = mcr_pkg::RADIUS_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_row[9:0], center_col[19:10], radius[25:20]
	input  logic [31:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// row_plus_a, row_minus_a, row_plus_b, row_minus_b, col_plus_a,
	// col_minus_a, col_plus_b, col_minus_b (12 bits each), point_mask[103:96]
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	import mcr_pkg::*;

	job_t      in_job;
	job_t      push_job;
	job_t      pop_job;
	logic      push_valid;
	logic      push_ready;
	logic      pop_valid;
	logic      pop_ready;
	res_t      res;
	q_stat_t   q_stat;
	eng_stat_t eng_stat;

	assign in_job.row = s_axis_tdata[9:0];
	assign in_job.col = s_axis_tdata[19:10];
	assign in_job.rad = s_axis_tdata[25:20];

	mcr_front #(
		.RADIUS_MAX(RADIUS_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_job    (in_job),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job)
	);

	mcr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_job  (push_job),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_job  (pop_job),
		.stat    (q_stat)
	);

	mcr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job_ready(pop_ready),
		.job      (pop_job),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res),
		.res_last (m_axis_tlast),
		.stat     (eng_stat)
	);

	assign m_axis_tdata = {res.point_mask, res.col_minus_b, res.col_plus_b,
		res.col_minus_a, res.col_plus_a, res.row_minus_b, res.row_plus_b,
		res.row_minus_a, res.row_plus_a};

	a_busy_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.busy |-> m_axis_tvalid)
		else $error("engine running without a pending result");

	a_diag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.point_mask == MASK_DIAG) |-> m_axis_tlast)
		else $error("diagonal point not marked last");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.point_mask == MASK_SINGLE) |-> m_axis_tlast)
		else $error("zero radius result not marked last");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.count <= CNT_W'(MAX_RESULTS))
		else $error("result count beyond cap");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= ($bits(q_stat.count))'(QUEUE_DEPTH))
		else $error("queue overfilled");

endmodule
